// ===== sv/fl2_pkg.sv =====
// Shared types and constants for the base-2 logarithm pipeline.
`timescale 1ns / 1ps
package fl2_pkg;

  localparam int unsigned SigW  = 24;
  localparam int unsigned FracW = 23;
  localparam int unsigned ExpW  = 8;
  localparam int unsigned FixW  = ExpW + FracW;

  // Item state carried down the squaring pipeline.
  typedef struct packed {
    logic [ExpW-1:0]  expo;
    logic [SigW-1:0]  sig;
    logic [FracW-1:0] frac;
  } fl2_work_t;

endpackage

// ===== sv/fl2_sq_stage.sv =====
// One squaring round: square, round to 24 bits, emit one fraction bit.
`timescale 1ns / 1ps
module fl2_sq_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fl2_pkg::fl2_work_t in_work,
  output logic              out_valid,
  input  logic              out_ready,
  output fl2_pkg::fl2_work_t out_work
);

  logic                valid_r;
  fl2_pkg::fl2_work_t  work_r;
  fl2_pkg::fl2_work_t  work_nxt;
  logic [47:0]         sq;
  logic [24:0]         q_hi;
  logic [24:0]         q_lo;

  assign sq = 48'(in_work.sig) * 48'(in_work.sig);

  // Round to nearest even at the two possible binary points.
  assign q_hi = {1'b0, sq[47:24]} + 25'(sq[23] & ((|sq[22:0]) | sq[24]));
  assign q_lo = {1'b0, sq[46:23]} + 25'(sq[22] & ((|sq[21:0]) | sq[23]));

  always_comb begin
    work_nxt.expo = in_work.expo;
    if (sq[47]) begin
      // Square is 2 or more: halve it and record a one.
      work_nxt.sig  = q_hi[23:0];
      work_nxt.frac = {in_work.frac[21:0], 1'b1};
    end else if (q_lo[24]) begin
      // Square rounded up to exactly 2, which halves to exactly 1.
      work_nxt.sig  = {1'b1, 23'd0};
      work_nxt.frac = {in_work.frac[21:0], 1'b1};
    end else begin
      work_nxt.sig  = q_lo[23:0];
      work_nxt.frac = {in_work.frac[21:0], 1'b0};
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_work  = work_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      work_r <= work_nxt;
    end
  end

endmodule

// ===== sv/fl2_to_float.sv =====
// Three-stage conversion of the Q8.23 logarithm to IEEE single bits.
`timescale 1ns / 1ps
module fl2_to_float (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [30:0] in_fixed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] out_fixed,
  output logic [31:0] out_float
);

  logic        a_valid_r, b_valid_r, c_valid_r;
  logic        a_rdy, b_rdy, c_rdy;
  logic [30:0] a_fixed_r, b_fixed_r, c_fixed_r;
  logic [30:0] a_mag_r, b_mag_r;
  logic        a_sign_r, b_sign_r, b_zero_r;
  logic [4:0]  b_k_r;
  logic [31:0] c_float_r;
  logic [4:0]  k_nxt;
  logic [30:0] norm;
  logic [24:0] sum;
  logic        up;
  logic [22:0] mant;
  logic [7:0]  expo;
  logic [31:0] float_nxt;

  assign c_rdy    = !c_valid_r || out_ready;
  assign b_rdy    = !b_valid_r || c_rdy;
  assign a_rdy    = !a_valid_r || b_rdy;
  assign in_ready = a_rdy;

  // Position of the leading one of the magnitude.
  always_comb begin
    k_nxt = 5'd0;
    for (int i = 0; i < 31; i++) begin
      if (a_mag_r[i]) k_nxt = 5'(i);
    end
  end

  // Normalize, round nearest even, pack.
  always_comb begin
    norm = b_mag_r << (5'd30 - b_k_r);
    up   = norm[6] & ((|norm[5:0]) | norm[7]);
    sum  = {1'b0, norm[30:7]} + 25'(up);
    mant = sum[24] ? sum[23:1] : sum[22:0];
    expo = 8'(b_k_r) + 8'd104 + 8'(sum[24]);
    if (b_zero_r) begin
      float_nxt = 32'd0;
    end else begin
      float_nxt = {b_sign_r, expo, mant};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (a_rdy) a_valid_r <= in_valid;
      if (b_rdy) b_valid_r <= a_valid_r;
      if (c_rdy) c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && in_valid) begin
      a_fixed_r <= in_fixed;
      a_sign_r  <= in_fixed[30];
      a_mag_r   <= in_fixed[30] ? (31'd0 - in_fixed) : in_fixed;
    end
    if (b_rdy && a_valid_r) begin
      b_fixed_r <= a_fixed_r;
      b_sign_r  <= a_sign_r;
      b_mag_r   <= a_mag_r;
      b_k_r     <= k_nxt;
      b_zero_r  <= (a_mag_r == 31'd0);
    end
    if (c_rdy && b_valid_r) begin
      c_fixed_r <= b_fixed_r;
      c_float_r <= float_nxt;
    end
  end

  assign out_valid = c_valid_r;
  assign out_fixed = c_fixed_r;
  assign out_float = c_float_r;

endmodule

// ===== sv/float_log2_by_squaring.sv =====
// Top level of the pipelined base-2 logarithm of an IEEE single value.
`timescale 1ns / 1ps
// This block takes the bits of a positive IEEE single value and returns its
// base-2 logarithm both as a signed Q8.23 number and as IEEE single bits.
// The integer part is the biased exponent minus 127, wrapped to 8 bits; the
// sign bit is ignored, infinity and NaN read as exponent -128, and zero or
// denormal inputs are taken as 1.m times 2^-127. Each fraction bit comes from
// one squaring round of the significand, and every round has a pipeline
// stage of its own with a 24 by 24 bit multiplier. The block accepts one item
// in every cycle while its output is not stalled, and it has one decode stage,
// one stage per round and three stages for the float conversion.
// Every stage holds its item under back-pressure, so a stalled output never
// drops or repeats an item, and the input keeps flowing while empty stages
// remain ahead of it.
module float_log2_by_squaring #(
  parameter int unsigned FRACTION_BITS = 23
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_value_bits,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [30:0] out_log_fixed,
  output logic [31:0]        out_log_float_bits
);

  localparam int unsigned Pad = 23 - FRACTION_BITS;

  // Chain index 0 is the decode stage; index n is after round n.
  logic               chain_valid [FRACTION_BITS+1];
  logic               chain_ready [FRACTION_BITS+1];
  fl2_pkg::fl2_work_t chain_work  [FRACTION_BITS+1];

  logic               dec_valid_r;
  fl2_pkg::fl2_work_t dec_work_r;
  fl2_pkg::fl2_work_t dec_work_nxt;
  logic [22:0]        frac_aligned;
  logic [30:0]        fixed_val;
  logic [30:0]        conv_fixed;

  // Decode: unbiased exponent wraps modulo 256, significand gets its hidden one.
  always_comb begin
    dec_work_nxt.expo = in_value_bits[30:23] - 8'd127;
    dec_work_nxt.sig  = {1'b1, in_value_bits[22:0]};
    dec_work_nxt.frac = 23'd0;
  end

  assign in_ready = !dec_valid_r || chain_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_valid_r <= 1'b0;
    end else if (in_ready) begin
      dec_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      dec_work_r <= dec_work_nxt;
    end
  end

  assign chain_valid[0] = dec_valid_r;
  assign chain_work[0]  = dec_work_r;

  // One squaring stage for each fraction bit.
  for (genvar g = 0; g < FRACTION_BITS; g++) begin : g_round
    fl2_sq_stage u_sq (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_valid[g]),
      .in_ready  (chain_ready[g]),
      .in_work   (chain_work[g]),
      .out_valid (chain_valid[g+1]),
      .out_ready (chain_ready[g+1]),
      .out_work  (chain_work[g+1])
    );
  end

  // Fraction bits were shifted in from the bottom; left-align them.
  assign frac_aligned = chain_work[FRACTION_BITS].frac << Pad;
  assign fixed_val    = {chain_work[FRACTION_BITS].expo, frac_aligned};

  fl2_to_float u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chain_valid[FRACTION_BITS]),
    .in_ready  (chain_ready[FRACTION_BITS]),
    .in_fixed  (fixed_val),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_fixed (conv_fixed),
    .out_float (out_log_float_bits)
  );

  assign out_log_fixed = $signed(conv_fixed);

endmodule

// ===== dv/tb_float_log2_by_squaring.sv =====
// Self-checking testbench for the pipelined base-2 logarithm block.
`timescale 1ns / 1ps
// The testbench feeds IEEE single bit patterns into the block and checks every
// result against a predictor that repeats the squaring algorithm bit for bit.
// Both sides of the handshake idle at random, and once the receiver holds off
// for a long stretch so that the pipeline fills and stalls the input.

// Predicts log2 results and checks them in order of arrival.
class log2_scoreboard;
  logic signed [30:0] fixed_q[$];
  logic [31:0]        float_q[$];
  int                 mismatches;

  static function logic [63:0] round_shift(logic [63:0] v, int unsigned sh);
    logic [63:0] q, rem, half;
    q = v >> sh;
    rem = v & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q++;
    return q;
  endfunction

  static function int unsigned msb_index(logic [63:0] v);
    int unsigned k;
    k = 63;
    while (k > 0 && !v[k]) k--;
    return k;
  endfunction

  // Rounds a Q8.23 value to IEEE single bits, nearest-even.
  static function logic [31:0] q823_to_single(longint v);
    logic        sgn;
    logic [63:0] mag, mant;
    int unsigned k;
    if (v == 0) return 32'd0;
    sgn = v < 0;
    mag = sgn ? -v : v;
    k = msb_index(mag);
    if (k <= 23) mant = mag << (23 - k);
    else begin
      mant = round_shift(mag, k - 23);
      if (mant[24]) begin
        mant = mant >> 1;
        k++;
      end
    end
    return {sgn, 8'(k + 104), mant[22:0]};
  endfunction

  // Notes an accepted input item and queues its expected result.
  function void note_input(logic [31:0] bits);
    int          expo;
    logic [63:0] sig, sq, q;
    logic [22:0] frac;
    int unsigned k, sh;
    int          t;
    logic        ge;
    longint      fx;
    expo = int'(bits[30:23]) - 127;
    if (expo == 128) expo = -128;
    sig = {40'd1, bits[22:0]};
    frac = '0;
    for (int i = 0; i < 23; i++) begin
      sq = sig * sig;
      k = msb_index(sq);
      sh = k - 23;
      q = round_shift(sq, sh);
      ge = (q << sh) >= (64'd1 << 47);
      t = int'(sh) - 23 - (ge ? 1 : 0);
      frac = {frac[21:0], ge};
      sig = (t >= 0) ? (q << t) : (q >> (-t));
    end
    fx = longint'(expo) * 8388608 + longint'(frac);
    fixed_q.push_back(fx[30:0]);
    float_q.push_back(q823_to_single(fx));
  endfunction

  function void check_result(logic signed [30:0] fixed, logic [31:0] fbits);
    logic signed [30:0] ef;
    logic [31:0]        eb;
    if (fixed_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result fixed=%h float=%h", fixed, fbits);
      return;
    end
    ef = fixed_q.pop_front();
    eb = float_q.pop_front();
    if (ef !== fixed || eb !== fbits) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result wrong: fixed exp %h got %h, float exp %h got %h", ef, fixed, eb, fbits);
    end
  endfunction
endclass

module tb_float_log2_by_squaring;
  localparam int RandomItems = 530;
  localparam int IdleLimit   = 20000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [31:0]        in_value_bits;
  logic               out_valid;
  logic               out_ready;
  logic signed [30:0] out_log_fixed;
  logic [31:0]        out_log_float_bits;

  log2_scoreboard sb;
  logic [31:0]    value_list[$];
  bit             feeding_done;
  bit             hold_off;
  int             idle_cycles;

  float_log2_by_squaring dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_value_bits      (in_value_bits),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_log_fixed      (out_log_fixed),
    .out_log_float_bits (out_log_float_bits)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Random wait before an item; about one draw in four is forced to no wait so
  // that stretches without idling also occur.
  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
  endfunction

  // Offers one item and holds it until the block accepts it.
  task automatic send_value(logic [31:0] bits);
    in_valid      <= 1'b1;
    in_value_bits <= bits;
    do @(posedge clk); while (!in_ready);
    sb.note_input(bits);
  endtask

  // Directed corners: exponent extremes, infinity and NaN, zero and denormals,
  // the sign bit, exact powers of two, and significands whose squares round up
  // to exactly two.
  initial begin
    value_list = '{32'h3f800000, 32'h00000000, 32'h80000000, 32'h00000001, 32'h007fffff,
                   32'h7f800000, 32'h7fffffff, 32'hffffffff, 32'h7f7fffff, 32'h00800000,
                   32'h40000000, 32'h3f000000, 32'h3fb504f3, 32'h3fb504f4, 32'h3fffffff,
                   32'h3f800001, 32'h43000000, 32'h42fe0000, 32'hbf800000, 32'h55555555,
                   32'haaaaaaaa, 32'h3fc00000};
    for (int i = 0; i < RandomItems; i++) begin
      case ($urandom_range(0, 3))
        0: value_list.push_back($urandom());
        1: value_list.push_back({$urandom_range(0, 1) == 1, 8'($urandom_range(120, 134)),
                                 23'($urandom())});
        2: value_list.push_back({1'b0, 8'($urandom_range(0, 255)), 23'($urandom_range(0, 7))});
        default: value_list.push_back({9'h07f, 23'h7fffff - 23'($urandom_range(0, 15))});
      endcase
    end
  end

  // Sender.
  initial begin
    sb = new();
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_value_bits <= '0;
    feeding_done  = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (value_list[i]) begin
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      send_value(value_list[i]);
    end
    in_valid     <= 1'b0;
    feeding_done = 1'b1;
  end

  // Long receiver hold-off once the random part is underway. It lasts long
  // enough for the sender to fill every pipeline stage.
  initial begin
    hold_off = 1'b0;
    repeat (400) @(posedge clk);
    hold_off = 1'b1;
    repeat (600) @(posedge clk);
    hold_off = 1'b0;
  end

  // Receiver: random stalls between items.
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = draw_gap();
      if (stall > 0 || hold_off) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_log_fixed, out_log_float_bits);
    end
  end

  // Watchdog and end of run.
  initial begin
    idle_cycles = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("float_log2_by_squaring: mismatch");
        $finish;
      end
      if (feeding_done && sb.fixed_q.size() == 0) break;
    end
    // Any extra output would show up within the pipeline latency.
    repeat (60) @(posedge clk);
    if (sb.mismatches == 0 && sb.fixed_q.size() == 0) begin
      $display("float_log2_by_squaring: match");
    end else begin
      $display("float_log2_by_squaring: mismatch");
    end
    $finish;
  end
endmodule
